FILE: src/nfh_pkg.sv
// nfh_pkg: types and constants for the next-fit heap allocator core
// heap geometry, header layout, transfer structs and controller states
// no dependencies
`default_nettype none

package nfh_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int BRK_W      = ADDR_W + 1;
  localparam int SIZE_W     = 12;
  localparam int ENTRY_W    = SIZE_W + 1;
  localparam int HDR_WORDS  = 2;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic              success;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_WR,
    S_WALK,
    S_TAKE,
    S_SPLIT,
    S_GROW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/next_fit_heap_allocator_core.sv
// next_fit_heap_allocator_core: next-fit allocator over a single-port header memory
// depends on nfh_pkg; one memory access per cycle, the walk checks one block header per read
// free reads the header and writes it back marked free; allocate grows an empty heap, else
//   walks headers from the rover on, takes the first fit (split if large) or grows the break
// throughput: one operation at a time, set by the single memory port and the walk loop
// reset: break and rover cleared, header memory left unwritten (no clearing pass)
`default_nettype none

module next_fit_heap_allocator_core
  import nfh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire nfh_pkg::in_item_t   in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      nfh_pkg::out_item_t  out_data
);

  state_t state, state_next;

  logic [ENTRY_W-1:0] mem [HEAP_WORDS];
  logic [ENTRY_W-1:0] rdata;
  logic               mem_re;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [BRK_W-1:0]   brk;
  logic [ADDR_W-1:0]  rover;
  logic [ADDR_W-1:0]  cur;
  logic [SIZE_W-1:0]  req_n;
  logic [BRK_W-1:0]   iter;
  logic               check_en;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_ok;

  logic               accept;
  logic [SIZE_W-1:0]  in_n;
  logic [ADDR_W+1:0]  walk_sum;
  logic [ADDR_W-1:0]  walk_nxt;
  logic               walk_fit;
  logic               walk_stop;
  logic [SIZE_W-1:0]  rem;
  logic               do_split;
  logic [ADDR_W:0]    split_sum;
  logic [ADDR_W+1:0]  grow_sum;
  logic               grow_ok;
  logic [BRK_W-1:0]   grow_base;
  logic [ADDR_W-1:0]  grow_addr;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_n     = (in_data.request_size == '0) ? SIZE_W'(1) : in_data.request_size;
  assign out_free = !out_valid || out_ready;

  // next block in the walk, wrapping from the break to the first block
  assign walk_sum  = {2'b00, cur} + {2'b00, rdata[SIZE_W-1:0]} + (ADDR_W+2)'(HDR_WORDS);
  assign walk_nxt  = (walk_sum >= {1'b0, brk}) ? ADDR_W'(HDR_WORDS) : walk_sum[ADDR_W-1:0];
  assign walk_fit  = check_en && !rdata[SIZE_W] && (rdata[SIZE_W-1:0] >= req_n);
  assign walk_stop = check_en && ((cur == rover) || (iter == BRK_W'(HEAP_WORDS)));

  assign rem       = rdata[SIZE_W-1:0] - req_n;
  assign do_split  = rem >= SIZE_W'(HDR_WORDS + 1);
  assign split_sum = {1'b0, cur} + {1'b0, req_n} + (ADDR_W+1)'(HDR_WORDS);

  assign grow_sum  = {1'b0, brk} + {2'b00, req_n} + (ADDR_W+2)'(HDR_WORDS);
  assign grow_ok   = grow_sum <= (ADDR_W+2)'(HEAP_WORDS);
  assign grow_base = brk + BRK_W'(HDR_WORDS);
  assign grow_addr = grow_base[ADDR_W-1:0];

  // header memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_FREE) begin
            state_next = S_FREE_WR;
          end else if (brk != '0) begin
            state_next = S_WALK;
          end else begin
            state_next = S_GROW;
          end
        end
      end
      S_FREE_WR: state_next = S_DONE;
      S_WALK: begin
        if (walk_fit) begin
          state_next = S_TAKE;
        end else if (walk_stop) begin
          state_next = S_GROW;
        end
      end
      S_TAKE:  state_next = do_split ? S_SPLIT : S_DONE;
      S_SPLIT: state_next = S_DONE;
      S_GROW:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cur;
    mem_wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_FREE) begin
            mem_re   = 1'b1;
            mem_addr = in_data.block_address;
          end else if (brk != '0) begin
            mem_re   = 1'b1;
            mem_addr = rover;
          end
        end
      end
      S_FREE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, rdata[SIZE_W-1:0]};
      end
      S_WALK: begin
        if (!walk_fit && !walk_stop) begin
          mem_re   = 1'b1;
          mem_addr = walk_nxt;
        end
      end
      S_TAKE: begin
        mem_we    = 1'b1;
        mem_wdata = do_split ? {1'b1, req_n} : {1'b1, rdata[SIZE_W-1:0]};
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_addr  = split_sum[ADDR_W-1:0];
        mem_wdata = {1'b0, SIZE_W'(rem - SIZE_W'(HDR_WORDS))};
      end
      S_GROW: begin
        if (grow_ok) begin
          mem_we    = 1'b1;
          mem_addr  = grow_addr;
          mem_wdata = {1'b1, req_n};
        end
      end
      S_DONE: begin
        mem_re = 1'b0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      brk       <= '0;
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_TAKE) begin
        rover <= cur;
      end
      if (state == S_GROW && grow_ok) begin
        brk   <= grow_sum[BRK_W-1:0];
        rover <= grow_addr;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= (in_data.action == ACT_FREE) ? in_data.block_address : rover;
      req_n    <= in_n;
      iter     <= '0;
      check_en <= 1'b0;
      res_addr <= '0;
      res_ok   <= (in_data.action == ACT_FREE);
    end
    if (state == S_WALK && !walk_fit && !walk_stop) begin
      cur      <= walk_nxt;
      iter     <= iter + BRK_W'(1);
      check_en <= 1'b1;
    end
    if (state == S_TAKE) begin
      res_addr <= cur;
      res_ok   <= 1'b1;
    end
    if (state == S_GROW && grow_ok) begin
      res_addr <= grow_addr;
      res_ok   <= 1'b1;
    end
    if (state == S_DONE && out_free) begin
      out_data.granted_address <= res_addr;
      out_data.success         <= res_ok;
    end
  end

`ifndef ASSERT_OFF
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_re && mem_we))
    else $error("header memory read and written in one cycle");

  a_break_bound: assert property (@(posedge clk) disable iff (rst)
    brk <= BRK_W'(HEAP_WORDS))
    else $error("break past end of heap");

  a_walk_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && check_en) |-> ({1'b0, cur} < brk))
    else $error("walk left the heap");

  a_grow_rover: assert property (@(posedge clk) disable iff (rst)
    (state == S_GROW && grow_ok) |=> (rover == $past(grow_addr)))
    else $error("rover not moved to grown block");

  a_take_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> (mem_we && mem_addr == cur && mem_wdata[SIZE_W]))
    else $error("taken block not marked used");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking testbench for next_fit_heap_allocator_core
// a header-map predictor checks every result; directed cases, then random alloc/free traffic
// depends on nfh_pkg and the core rtl
import nfh_pkg::*;

class heap_tracker;
  logic [ENTRY_W-1:0] heap_hdr [HEAP_WORDS];
  bit                 written [HEAP_WORDS];
  int                 written_list [$];
  int                 live [$];
  int                 brk;
  int                 rover;
  int                 last_grant;
  int                 mismatches;
  out_item_t          grants_due [$];

  function new();
    foreach (heap_hdr[i]) heap_hdr[i] = '0;
    brk = 0;
    rover = 0;
    last_grant = 0;
    mismatches = 0;
  endfunction

  function void put_header(int a, bit used, int size);
    heap_hdr[a] = {used, size[SIZE_W-1:0]};
    if (!written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endfunction

  function out_item_t predict_grant(in_item_t it);
    out_item_t r;
    int n, cur, nxt, hit, have, rem;
    r = '0;
    hit = 0;
    if (it.action == ACT_FREE) begin
      heap_hdr[it.block_address][SIZE_W] = 1'b0;
      r.success = 1'b1;
      return r;
    end
    n = (it.request_size == 0) ? 1 : int'(it.request_size);
    // next-fit walk, start block checked last
    if (brk != 0) begin
      cur = rover;
      for (int i = 0; i < HEAP_WORDS; i++) begin
        nxt = cur + int'(heap_hdr[cur][SIZE_W-1:0]) + HDR_WORDS;
        if (nxt >= brk) nxt = HDR_WORDS;
        cur = nxt;
        if (!heap_hdr[cur][SIZE_W] && int'(heap_hdr[cur][SIZE_W-1:0]) >= n) begin
          hit = cur;
          break;
        end
        if (cur == rover) break;
      end
    end
    if (hit != 0) begin
      have = int'(heap_hdr[hit][SIZE_W-1:0]);
      rem = have - n;
      if (rem >= HDR_WORDS + 1) begin
        put_header(hit, 1'b1, n);
        put_header(hit + n + HDR_WORDS, 1'b0, rem - HDR_WORDS);
      end else begin
        put_header(hit, 1'b1, have);
      end
    end else if (brk + n + HDR_WORDS <= HEAP_WORDS) begin
      hit = brk + HDR_WORDS;
      put_header(hit, 1'b1, n);
      brk = brk + n + HDR_WORDS;
    end
    if (hit != 0) begin
      rover = hit;
      live.push_back(hit);
      r.granted_address = hit[ADDR_W-1:0];
      r.success = 1'b1;
    end
    last_grant = hit;
    return r;
  endfunction

  function void note_request(in_item_t it);
    grants_due.push_back(predict_grant(it));
  endfunction

  function void check_grant(out_item_t got);
    out_item_t want;
    if (grants_due.size() == 0) begin
      $error("unexpected result: granted_address %0d success %0b",
             got.granted_address, got.success);
      mismatches++;
      return;
    end
    want = grants_due.pop_front();
    if (got.granted_address !== want.granted_address) begin
      $error("granted_address: expected %0d, actual %0d",
             want.granted_address, got.granted_address);
      mismatches++;
    end
    if (got.success !== want.success) begin
      $error("success: expected %0b, actual %0b", want.success, got.success);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  heap_tracker sb;

  next_fit_heap_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_grant(out_data);
  end

  task automatic issue(action_t act, int unsigned size, int unsigned addr);
    in_item_t it;
    it.action = act;
    it.request_size = size[SIZE_W-1:0];
    it.block_address = addr[ADDR_W-1:0];
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.grants_due.size() != 0) @(posedge clk);
  endtask

  task automatic directed_ops();
    int a_big, a_mid, a_top, a_fill;
    issue(ACT_ALLOC, 0, 4095);      // zero request on an empty heap
    issue(ACT_ALLOC, 4095, 0);      // larger than the whole heap
    issue(ACT_ALLOC, 10, 0);
    a_big = sb.last_grant;
    issue(ACT_ALLOC, 3, 0);
    a_mid = sb.last_grant;
    issue(ACT_FREE, 0, a_big);
    issue(ACT_ALLOC, 4, 0);         // split
    issue(ACT_ALLOC, 2, 0);         // remainder too small to split
    issue(ACT_ALLOC, 7, 0);
    a_top = sb.last_grant;
    issue(ACT_FREE, 4095, a_top);
    issue(ACT_ALLOC, 7, 0);         // start block found last
    issue(ACT_FREE, 0, a_mid);
    issue(ACT_FREE, 0, a_mid);      // double free
    issue(ACT_ALLOC, 3, 0);         // exact fit
    issue(ACT_ALLOC, HEAP_WORDS - sb.brk - 1, 0);  // one word past the end
    issue(ACT_ALLOC, HEAP_WORDS - sb.brk - 2, 0);  // ends exactly at the end
    a_fill = sb.last_grant;
    issue(ACT_ALLOC, 1, 0);         // heap full, nothing free
    issue(ACT_FREE, 0, a_fill);
    issue(ACT_ALLOC, 4094, 4095);
    issue(ACT_ALLOC, 1, 2048);
  endtask

  task automatic random_ops(int count);
    int unsigned roll, pick, size, addr;
    repeat (count) begin
      roll = $urandom_range(99);
      if (sb.live.size() != 0 && roll < 45) begin
        if ($urandom_range(99) < 85) begin
          pick = $urandom_range(sb.live.size() - 1);
          addr = sb.live[pick];
          sb.live.delete(pick);
        end else begin
          addr = sb.written_list[$urandom_range(sb.written_list.size() - 1)];
        end
        issue(ACT_FREE, $urandom_range(4095), addr);
      end else begin
        roll = $urandom_range(99);
        if (roll < 3) size = 0;
        else if (roll < 80) size = $urandom_range(32, 1);
        else if (roll < 96) size = $urandom_range(400, 33);
        else size = $urandom_range(4095, 401);
        issue(ACT_ALLOC, size, $urandom_range(4095));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_ops();
    wait_drain();

    random_ops(60);
    hold_req = 1'b1;
    random_ops(125);
    wait_drain();

    send_idle_pct = 81;
    random_ops(185);
    wait_drain();

    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_ops(185);
    wait_drain();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    random_ops(185);
    wait_drain();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.grants_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #300000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
